// ===== rtl/hcb_pkg.sv =====
// Package for the Hill cipher block unit: widths, register indexes, modes and
// the mod 26 arithmetic helpers. No dependencies.
`timescale 1ns / 1ps

package hcb_pkg;

  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned NUM_LETTERS   = 4;
  localparam int unsigned KEY_ROW_W     = NUM_LETTERS * LETTER_W;
  localparam int unsigned BSIZE_W       = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MAX_ORDER_DEF = 4;
  localparam int unsigned DEC_ORDER     = 2;
  localparam int unsigned NUM_STAGES    = 4;
  localparam int unsigned MODULUS       = 26;
  localparam int unsigned PROD_W        = 2 * LETTER_W;
  localparam int unsigned MOD_IN_W      = 12;
  localparam int unsigned RECIP_SHIFT   = 16;
  localparam int unsigned RECIP_26      = ((1 << RECIP_SHIFT) + MODULUS - 1) / MODULUS;
  localparam int unsigned MOD_PROD_W    = MOD_IN_W + RECIP_SHIFT;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_ROW0   = 3'd0,
    CFG_KEY_ROW1   = 3'd1,
    CFG_KEY_ROW2   = 3'd2,
    CFG_KEY_ROW3   = 3'd3,
    CFG_BLOCK_SIZE = 3'd4,
    CFG_MODE       = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_e;

  // Reciprocal multiply; the quotient estimate is exact for every 12-bit input.
  function automatic letter_t mod26(input logic [MOD_IN_W-1:0] x);
    logic [MOD_PROD_W-1:0] prod;
    logic [MOD_IN_W-1:0]   q;
    logic [MOD_IN_W-1:0]   r;
    prod = MOD_PROD_W'(x) * MOD_PROD_W'(RECIP_26);
    q    = MOD_IN_W'(prod >> RECIP_SHIFT);
    r    = x - (q * MOD_IN_W'(MODULUS));
    return r[LETTER_W-1:0];
  endfunction

  function automatic letter_t red26(input letter_t x);
    return (x >= LETTER_W'(MODULUS)) ? x - LETTER_W'(MODULUS) : x;
  endfunction

  function automatic letter_t neg26(input letter_t x);
    return (x == '0) ? '0 : LETTER_W'(MODULUS) - x;
  endfunction

  function automatic letter_t mul_mod26(input letter_t x, input letter_t y);
    return mod26(MOD_IN_W'(PROD_W'(x) * PROD_W'(y)));
  endfunction

  // Multiplicative inverse mod 26, zero when none exists.
  function automatic letter_t inv_mod26(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hcb_if.sv =====
// Valid/ready channel interfaces for the input and result beats of the
// Hill cipher block unit. Depends on hcb_pkg.
`timescale 1ns / 1ps

interface hcb_in_if import hcb_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter0;
  letter_t letter1;
  letter_t letter2;
  letter_t letter3;

  modport source (output valid, output letter0, output letter1, output letter2,
                  output letter3, input ready);
  modport sink (input valid, input letter0, input letter1, input letter2,
                input letter3, output ready);
endinterface

interface hcb_out_if import hcb_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t out_letter0;
  letter_t out_letter1;
  letter_t out_letter2;
  letter_t out_letter3;
  logic    key_error;

  modport source (output valid, output out_letter0, output out_letter1,
                  output out_letter2, output out_letter3, output key_error,
                  input ready);
  modport sink (input valid, input out_letter0, input out_letter1,
                input out_letter2, input out_letter3, input key_error,
                output ready);
endinterface

// ===== rtl/hcb_keyprep.sv =====
// Three-stage key preparation: forms the working matrix (key or inverse 2x2
// key) and the error flag alongside each beat. Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_keyprep import hcb_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                                  clk_i,
  input  logic [NUM_LETTERS-1:0][KEY_ROW_W-1:0] key_rows_i,
  input  logic [BSIZE_W-1:0]                    block_size_i,
  input  mode_e                                 mode_i,
  input  logic [2:0]                            load_i,
  output letter_t                               mat_o [MAX_ORDER][MAX_ORDER],
  output logic                                  err_o
);

  letter_t             ra, rb, rc, rd;
  logic [PROD_W-1:0]   ad_q, bc_q;
  logic [MOD_IN_W-1:0] det_sum;
  letter_t             di_q;
  letter_t             mat_d [MAX_ORDER][MAX_ORDER];
  letter_t             mat_q [MAX_ORDER][MAX_ORDER];
  logic                err_d, err_q;

  assign ra = red26(key_rows_i[0][0 +: LETTER_W]);
  assign rb = red26(key_rows_i[0][LETTER_W +: LETTER_W]);
  assign rc = red26(key_rows_i[1][0 +: LETTER_W]);
  assign rd = red26(key_rows_i[1][LETTER_W +: LETTER_W]);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      ad_q <= PROD_W'(ra) * PROD_W'(rd);
      bc_q <= PROD_W'(rb) * PROD_W'(rc);
    end
  end

  assign det_sum = MOD_IN_W'(ad_q) + MOD_IN_W'(MODULUS * MODULUS) - MOD_IN_W'(bc_q);

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      di_q <= inv_mod26(mod26(det_sum));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
        mat_d[i][j] = '0;
      end
    end
    err_d = 1'b0;
    if (block_size_i == '0 || int'(block_size_i) > MAX_ORDER) begin
      err_d = 1'b1;
    end else if (mode_i == MODE_ENCRYPT) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        for (int j = 0; j < MAX_ORDER; j++) begin
          if (i < int'(block_size_i) && j < int'(block_size_i)) begin
            mat_d[i][j] = key_rows_i[i][LETTER_W*j +: LETTER_W];
          end
        end
      end
    end else if (block_size_i != BSIZE_W'(DEC_ORDER)) begin
      err_d = 1'b1;
    end else if (di_q == '0) begin
      err_d = 1'b1;
    end else begin
      mat_d[0][0] = mul_mod26(di_q, rd);
      mat_d[0][1] = mul_mod26(di_q, neg26(rb));
      mat_d[1][0] = mul_mod26(di_q, neg26(rc));
      mat_d[1][1] = mul_mod26(di_q, ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      mat_q <= mat_d;
      err_q <= err_d;
    end
  end

  assign mat_o = mat_q;
  assign err_o = err_q;

endmodule

// ===== rtl/hcb_lane.sv =====
// One output lane: dot product of the block with one matrix column, mod 26.
// Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_lane import hcb_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  letter_t v_i   [MAX_ORDER],
  input  letter_t col_i [MAX_ORDER],
  output letter_t letter_o
);

  localparam int unsigned SUM_W = PROD_W + $clog2(MAX_ORDER);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_ORDER; j++) begin
      sum = sum + SUM_W'(PROD_W'(v_i[j]) * PROD_W'(col_i[j]));
    end
    letter_o = mod26(MOD_IN_W'(sum));
  end

endmodule

// ===== rtl/hcb_merge.sv =====
// Output stage: gathers the lane results into the result register, zeroing
// unused positions and every letter of an error beat. Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_merge import hcb_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic    clk_i,
  input  letter_t lane_i [MAX_ORDER],
  input  logic    err_i,
  input  logic    load_i,
  output letter_t letters_o [NUM_LETTERS],
  output logic    err_o
);

  letter_t letters_d [NUM_LETTERS];
  letter_t letters_q [NUM_LETTERS];
  logic    err_q;

  always_comb begin
    for (int i = 0; i < NUM_LETTERS; i++) begin
      letters_d[i] = '0;
    end
    for (int i = 0; i < MAX_ORDER; i++) begin
      letters_d[i] = err_i ? '0 : lane_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      letters_q <= letters_d;
      err_q     <= err_i;
    end
  end

  assign letters_o = letters_q;
  assign err_o     = err_q;

endmodule

// ===== rtl/hill_cipher_block_unit.sv =====
// Throughput: one block per cycle while result beats are taken; each pipeline stage refills as soon as it
// empties, so bubbles close up while a result waits at the output register.
// The key derivation (two multiply stages and the inverse lookup) sets the depth.
// Reset empties the pipeline and returns the registers to key 0, size 2, encrypt.
// Top level of the Hill cipher block unit; uses hcb_pkg, hcb_if, hcb_keyprep, the lanes and hcb_merge.
`timescale 1ns / 1ps

module hill_cipher_block_unit import hcb_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hcb_in_if.sink               blk_in_i,
  hcb_out_if.source            blk_out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KEY_ROW_W-1:0] cfg_wdata_i
);

  logic [NUM_LETTERS-1:0][KEY_ROW_W-1:0] key_rows_q;
  logic [BSIZE_W-1:0]                    block_size_q;
  mode_e                                 mode_q;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] rdy;

  letter_t lt_q [NUM_STAGES-1][NUM_LETTERS];
  letter_t mat [MAX_ORDER][MAX_ORDER];
  logic    mat_err;
  letter_t col [MAX_ORDER][MAX_ORDER];
  letter_t lane_v [MAX_ORDER];
  letter_t lane_out [MAX_ORDER];
  letter_t res_letters [NUM_LETTERS];
  logic    res_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_rows_q   <= '0;
      block_size_q <= BSIZE_W'(DEC_ORDER);
      mode_q       <= MODE_ENCRYPT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_ROW0:   key_rows_q[0] <= cfg_wdata_i;
        CFG_KEY_ROW1:   key_rows_q[1] <= cfg_wdata_i;
        CFG_KEY_ROW2:   key_rows_q[2] <= cfg_wdata_i;
        CFG_KEY_ROW3:   key_rows_q[3] <= cfg_wdata_i;
        CFG_BLOCK_SIZE: block_size_q  <= cfg_wdata_i[BSIZE_W-1:0];
        CFG_MODE:       mode_q        <= mode_e'(cfg_wdata_i[0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || blk_out_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign blk_in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= blk_in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      lt_q[0][0] <= blk_in_i.letter0;
      lt_q[0][1] <= blk_in_i.letter1;
      lt_q[0][2] <= blk_in_i.letter2;
      lt_q[0][3] <= blk_in_i.letter3;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (rdy[k]) begin
        lt_q[k] <= lt_q[k-1];
      end
    end
  end

  hcb_keyprep #(
    .MAX_ORDER(MAX_ORDER)
  ) u_keyprep (
    .clk_i        (clk_i),
    .key_rows_i   (key_rows_q),
    .block_size_i (block_size_q),
    .mode_i       (mode_q),
    .load_i       (rdy[2:0]),
    .mat_o        (mat),
    .err_o        (mat_err)
  );

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      lane_v[i] = lt_q[NUM_STAGES-2][i];
      for (int j = 0; j < MAX_ORDER; j++) begin
        col[i][j] = mat[j][i];
      end
    end
  end

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_lane
    hcb_lane #(
      .MAX_ORDER(MAX_ORDER)
    ) u_lane (
      .v_i      (lane_v),
      .col_i    (col[i]),
      .letter_o (lane_out[i])
    );
  end

  hcb_merge #(
    .MAX_ORDER(MAX_ORDER)
  ) u_merge (
    .clk_i     (clk_i),
    .lane_i    (lane_out),
    .err_i     (mat_err),
    .load_i    (rdy[NUM_STAGES-1]),
    .letters_o (res_letters),
    .err_o     (res_err)
  );

  assign blk_out_o.valid       = v_q[NUM_STAGES-1];
  assign blk_out_o.out_letter0 = res_letters[0];
  assign blk_out_o.out_letter1 = res_letters[1];
  assign blk_out_o.out_letter2 = res_letters[2];
  assign blk_out_o.out_letter3 = res_letters[3];
  assign blk_out_o.key_error   = res_err;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_out_o.valid && blk_out_o.key_error |->
      blk_out_o.out_letter0 == '0 && blk_out_o.out_letter1 == '0 &&
      blk_out_o.out_letter2 == '0 && blk_out_o.out_letter3 == '0)
    else $error("error beat carries nonzero letters");

  a_letter_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_out_o.valid |->
      blk_out_o.out_letter0 < LETTER_W'(MODULUS) &&
      blk_out_o.out_letter1 < LETTER_W'(MODULUS) &&
      blk_out_o.out_letter2 < LETTER_W'(MODULUS) &&
      blk_out_o.out_letter3 < LETTER_W'(MODULUS))
    else $error("result letter outside 0..25");

  a_size_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_out_o.valid && (block_size_q == '0 || int'(block_size_q) > MAX_ORDER) |->
      blk_out_o.key_error)
    else $error("bad block size without error flag");

endmodule

// ===== tb/tb_hill_cipher_block_unit.sv =====
// Self-checking testbench for hill_cipher_block_unit: a directed table and random
// key phases; each result beat is checked against the table's expected values
// or a mod 26 matrix predictor. Depends on hcb_pkg, hcb_if and the block's RTL.
`timescale 1ns / 1ps

module tb_hill_cipher_block_unit;
  import hcb_pkg::*;

  localparam int unsigned MAX_ORDER   = MAX_ORDER_DEF;
  localparam int unsigned LATENCY     = 4;
  localparam int unsigned RAND_ITEMS  = 850;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef letter_t [NUM_LETTERS-1:0] block_t;

  typedef struct packed {
    logic [NUM_LETTERS-1:0][KEY_ROW_W-1:0] rows;
    logic [BSIZE_W-1:0]                    bsize;
    mode_e                                 mode;
  } cipher_cfg_t;

  typedef struct packed {
    block_t ltr;
    logic   err;
  } cipher_res_t;

  typedef struct packed {
    cipher_cfg_t cfg;
    block_t      v;
    logic        known;
    cipher_res_t res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [KEY_ROW_W-1:0] cfg_wdata_i = '0;
  logic                 steady = 1'b0;
  int unsigned          mismatches = 0;
  cipher_cfg_t          cur_cfg;
  cipher_res_t          expected_q[$];
  stim_row_t            dir_tab[$];

  hcb_in_if  blk_in ();
  hcb_out_if blk_out ();

  hill_cipher_block_unit #(
    .MAX_ORDER(MAX_ORDER)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .blk_in_i   (blk_in),
    .blk_out_o  (blk_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [KEY_ROW_W-1:0] key_row(int e0, int e1, int e2, int e3);
    return {letter_t'(e3), letter_t'(e2), letter_t'(e1), letter_t'(e0)};
  endfunction

  function automatic cipher_cfg_t mk_cfg(logic [KEY_ROW_W-1:0] r0, logic [KEY_ROW_W-1:0] r1,
                                         logic [KEY_ROW_W-1:0] r2, logic [KEY_ROW_W-1:0] r3,
                                         int bsize, mode_e mode);
    cipher_cfg_t c;
    c.rows  = {r3, r2, r1, r0};
    c.bsize = BSIZE_W'(bsize);
    c.mode  = mode;
    return c;
  endfunction

  function automatic stim_row_t mk_row(cipher_cfg_t c, int l0, int l1, int l2, int l3,
                                       logic known, int e0, int e1, int e2, int e3,
                                       logic eerr);
    stim_row_t r;
    r.cfg       = c;
    r.v         = {letter_t'(l3), letter_t'(l2), letter_t'(l1), letter_t'(l0)};
    r.known     = known;
    r.res.ltr   = {letter_t'(e3), letter_t'(e2), letter_t'(e1), letter_t'(e0)};
    r.res.err   = eerr;
    return r;
  endfunction

  function automatic cipher_res_t encipher_block(cipher_cfg_t c, block_t v);
    cipher_res_t r;
    int unsigned m[NUM_LETTERS][NUM_LETTERS];
    int unsigned n, a, b, cc, d, det, di, s;
    r = '0;
    n = c.bsize;
    di = 0;
    for (int i = 0; i < NUM_LETTERS; i++)
      for (int j = 0; j < NUM_LETTERS; j++)
        m[i][j] = 0;
    if (n == 0 || n > MAX_ORDER || n > NUM_LETTERS) begin
      r.err = 1'b1;
    end else if (c.mode == MODE_ENCRYPT) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          m[i][j] = c.rows[i][LETTER_W*j +: LETTER_W];
    end else if (n != DEC_ORDER) begin
      r.err = 1'b1;
    end else begin
      a   = c.rows[0][0 +: LETTER_W] % MODULUS;
      b   = c.rows[0][LETTER_W +: LETTER_W] % MODULUS;
      cc  = c.rows[1][0 +: LETTER_W] % MODULUS;
      d   = c.rows[1][LETTER_W +: LETTER_W] % MODULUS;
      det = (a * d + MODULUS * MODULUS - b * cc) % MODULUS;
      for (int x = MODULUS - 1; x >= 1; x--)
        if ((det * x) % MODULUS == 1) di = x;
      if (di == 0) begin
        r.err = 1'b1;
      end else begin
        m[0][0] = (di * d) % MODULUS;
        m[0][1] = (di * ((MODULUS - b) % MODULUS)) % MODULUS;
        m[1][0] = (di * ((MODULUS - cc) % MODULUS)) % MODULUS;
        m[1][1] = (di * a) % MODULUS;
      end
    end
    if (!r.err) begin
      for (int i = 0; i < n; i++) begin
        s = 0;
        for (int j = 0; j < n; j++)
          s += v[j] * m[j][i];
        r.ltr[i] = letter_t'(s % MODULUS);
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_ROW_W-1:0] rand_key_row();
    if ($urandom_range(0, 5) == 0) return KEY_ROW_W'($urandom);
    return key_row($urandom_range(0, 25), $urandom_range(0, 25),
                   $urandom_range(0, 25), $urandom_range(0, 25));
  endfunction

  function automatic cipher_cfg_t rand_cfg();
    cipher_cfg_t c;
    for (int i = 0; i < NUM_LETTERS; i++)
      c.rows[i] = rand_key_row();
    c.mode = ($urandom_range(0, 1) == 0) ? MODE_ENCRYPT : MODE_DECRYPT;
    if (c.mode == MODE_DECRYPT)
      c.bsize = ($urandom_range(0, 4) != 0) ? BSIZE_W'(DEC_ORDER) : BSIZE_W'($urandom_range(0, 7));
    else if ($urandom_range(0, 6) != 0)
      c.bsize = BSIZE_W'($urandom_range(1, MAX_ORDER));
    else
      c.bsize = BSIZE_W'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic block_t rand_letters();
    block_t v;
    for (int i = 0; i < NUM_LETTERS; i++)
      v[i] = ($urandom_range(0, 6) != 0) ? letter_t'($urandom_range(0, 25))
                                         : letter_t'($urandom_range(0, 31));
    return v;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [KEY_ROW_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic apply_config(cipher_cfg_t c);
    @(negedge clk_i);
    blk_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    write_reg(CFG_KEY_ROW0, c.rows[0]);
    write_reg(CFG_KEY_ROW1, c.rows[1]);
    write_reg(CFG_KEY_ROW2, c.rows[2]);
    write_reg(CFG_KEY_ROW3, c.rows[3]);
    write_reg(CFG_BLOCK_SIZE, KEY_ROW_W'(c.bsize));
    write_reg(CFG_MODE, KEY_ROW_W'(c.mode));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_block(block_t v, logic known, cipher_res_t typed);
    int unsigned gap;
    gap = steady ? 0 : gap_len();
    @(negedge clk_i);
    if (gap != 0) begin
      blk_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    blk_in.valid   <= 1'b1;
    blk_in.letter0 <= v[0];
    blk_in.letter1 <= v[1];
    blk_in.letter2 <= v[2];
    blk_in.letter3 <= v[3];
    do @(posedge clk_i); while (!blk_in.ready);
    expected_q.push_back(known ? typed : encipher_block(cur_cfg, v));
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    blk_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (steady) begin
        blk_out.ready <= 1'b1;
      end else if (stall_left != 0) begin
        blk_out.ready <= 1'b0;
        stall_left--;
      end else begin
        blk_out.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin : result_check
    cipher_res_t exp_res, act;
    forever begin
      @(posedge clk_i);
      if (rst_ni && blk_out.valid && blk_out.ready) begin
        act.ltr = {blk_out.out_letter3, blk_out.out_letter2, blk_out.out_letter1,
                   blk_out.out_letter0};
        act.err = blk_out.key_error;
        if (expected_q.size() == 0) begin
          $error("result beat with no block pending: out_letter0..3=%0d %0d %0d %0d key_error=%0b",
                 act.ltr[0], act.ltr[1], act.ltr[2], act.ltr[3], act.err);
          mismatches++;
        end else begin
          exp_res = expected_q.pop_front();
          for (int i = 0; i < NUM_LETTERS; i++) begin
            if (act.ltr[i] !== exp_res.ltr[i]) begin
              $error("out_letter%0d: expected %0d, actual %0d", i, exp_res.ltr[i], act.ltr[i]);
              mismatches++;
            end
          end
          if (act.err !== exp_res.err) begin
            $error("key_error: expected %0b, actual %0b", exp_res.err, act.err);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    cipher_cfg_t rst_cfg, id4, max4, cls;
    int unsigned n_items, count;
    blk_in.valid   = 1'b0;
    blk_in.letter0 = '0;
    blk_in.letter1 = '0;
    blk_in.letter2 = '0;
    blk_in.letter3 = '0;

    rst_cfg = mk_cfg('0, '0, '0, '0, DEC_ORDER, MODE_ENCRYPT);
    id4  = mk_cfg(key_row(1, 0, 0, 0), key_row(0, 1, 0, 0), key_row(0, 0, 1, 0),
                  key_row(0, 0, 0, 1), 4, MODE_ENCRYPT);
    max4 = mk_cfg('1, '1, '1, '1, 4, MODE_ENCRYPT);
    cls  = mk_cfg(key_row(3, 3, 0, 0), key_row(2, 5, 0, 0), '0, '0, 2, MODE_DECRYPT);
    cur_cfg = rst_cfg;

    dir_tab.push_back(mk_row(rst_cfg, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(rst_cfg, 31, 31, 31, 31, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(id4, 25, 0, 13, 7, 1, 25, 0, 13, 7, 0));
    dir_tab.push_back(mk_row(id4, 31, 30, 29, 28, 1, 5, 4, 3, 2, 0));
    dir_tab.push_back(mk_row(max4, 31, 31, 31, 31, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(max4, 25, 25, 25, 25, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(key_row(25, 3, 7, 9), '1, '1, '1, 1, MODE_ENCRYPT),
                             25, 31, 31, 31, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(key_row(3, 10, 20, 31), key_row(17, 4, 9, 26),
                                    key_row(8, 25, 1, 13), key_row(30, 30, 30, 30),
                                    3, MODE_ENCRYPT), 1, 2, 3, 31, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(key_row(3, 10, 20, 31), key_row(17, 4, 9, 26),
                                    key_row(8, 25, 1, 13), key_row(30, 30, 30, 30),
                                    3, MODE_ENCRYPT), 25, 24, 23, 22, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg('1, '1, '1, '1, 0, MODE_ENCRYPT),
                             5, 6, 7, 8, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg('1, '1, '1, '1, 5, MODE_ENCRYPT),
                             5, 6, 7, 8, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg('1, '1, '1, '1, 7, MODE_ENCRYPT),
                             25, 25, 25, 25, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg('1, '1, '1, '1, 0, MODE_DECRYPT),
                             1, 2, 3, 4, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg('1, '1, '1, '1, 3, MODE_DECRYPT),
                             1, 2, 3, 4, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg(id4.rows[0], id4.rows[1], '0, '0, 1, MODE_DECRYPT),
                             9, 9, 9, 9, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg(id4.rows[0], id4.rows[1], id4.rows[2], id4.rows[3],
                                    4, MODE_DECRYPT), 9, 9, 9, 9, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg('0, '0, '0, '0, 2, MODE_DECRYPT),
                             7, 8, 0, 0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg(key_row(13, 0, 0, 0), key_row(0, 1, 0, 0), '0, '0,
                                    2, MODE_DECRYPT), 7, 8, 0, 0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg(key_row(2, 0, 0, 0), key_row(0, 1, 0, 0), '0, '0,
                                    2, MODE_DECRYPT), 7, 8, 0, 0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(mk_cfg(id4.rows[0], id4.rows[1], '0, '0, 2, MODE_DECRYPT),
                             3, 17, 25, 25, 1, 3, 17, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(key_row(27, 26, 31, 31), key_row(26, 27, 31, 31),
                                    '1, '1, 2, MODE_DECRYPT), 12, 31, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(cls, 7, 8, 25, 25, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(cls.rows[0], cls.rows[1], '0, '0, 2, MODE_ENCRYPT),
                             0, 25, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(mk_cfg(key_row(0, 1, 0, 0), key_row(1, 0, 0, 0), '0, '0,
                                    2, MODE_DECRYPT), 4, 19, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].cfg != cur_cfg) apply_config(dir_tab[k].cfg);
      send_block(dir_tab[k].v, dir_tab[k].known, dir_tab[k].res);
    end

    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      apply_config(rand_cfg());
      steady = ($urandom_range(0, 3) == 0);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 70);
      if (count > RAND_ITEMS - n_items) count = RAND_ITEMS - n_items;
      repeat (count) begin
        send_block(rand_letters(), 1'b0, '0);
        n_items++;
      end
    end

    @(negedge clk_i);
    blk_in.valid <= 1'b0;
    steady = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hcb_pkg.sv
rtl/hcb_if.sv
rtl/hcb_keyprep.sv
rtl/hcb_lane.sv
rtl/hcb_merge.sv
rtl/hill_cipher_block_unit.sv
tb/tb_hill_cipher_block_unit.sv
